### hw/rtl/gffc_pkg.sv
// Shared types and constants for the greedy first-fit coloring block.
`timescale 1ns / 1ps

package gffc_pkg;

    // Fixed field widths
    localparam int IDX_W      = 10;
    localparam int COLOR_W    = 7;
    localparam int VCOUNT_W   = 11;
    localparam int NUM_COLORS = 64;
    localparam int COLORIDX_W = 6;
    localparam int EPOCH_W    = 8;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1024;

    // Request actions
    typedef enum logic [1:0] {
        ACT_START    = 2'd0,
        ACT_NEIGHBOR = 2'd1,
        ACT_FINISH   = 2'd2,
        ACT_UNUSED   = 2'd3
    } t_action;

    // Result error codes
    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_VERTEX   = 2'd1,
        ERR_NEIGHBOR = 2'd2
    } t_error;

    // Input request payload
    typedef struct packed {
        logic [1:0]       action;
        logic [IDX_W-1:0] vertex;
        logic [IDX_W-1:0] neighbor;
    } t_in_req;

    // Result payload
    typedef struct packed {
        logic [IDX_W-1:0]   vertex_out;
        logic [COLOR_W-1:0] color;
        logic [COLOR_W-1:0] highest_color;
        logic [1:0]         error;
    } t_out_req;

    // One color store entry: epoch tag plus color
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [COLOR_W-1:0] color;
    } t_entry;

    // Write request into the color store
    typedef struct packed {
        logic   en;
        t_entry entry;
    } t_wr_ctl;

endpackage

### hw/rtl/greedy_first_fit_coloring_top.sv
// Top level of the greedy first-fit graph coloring block.
`timescale 1ns / 1ps

// Takes one request per cycle while o_ready is high: start, neighbor or
// finish. Each request is registered together with its color store read
// and resolved in the stage by a single first-fit pass over the 64-bit
// used-color mask; a finish holds the stage until the output register is
// free, then writes its result there. The store keeps an epoch tag per
// entry, so a start does not clear the store. After reset, and after every
// 256th start when the tag wraps, a clearing pass walks every store entry
// with o_ready low; a wrapping start also holds o_ready low while it is in
// the stage. The vertex_count register may be written at any time the
// block is idle.
module greedy_first_fit_coloring_top
    import gffc_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_DEGREE   = 63
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_in_req             i_req,
    output logic                o_valid,
    input  logic                i_ready,
    output t_out_req            o_res,
    input  logic                i_cfg_wr_en,
    input  logic [VCOUNT_W-1:0] i_cfg_wr_data
);

    localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    logic [VCOUNT_W-1:0] r_vcount;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    t_entry              rd_data;
    t_wr_ctl             core_wr;
    logic [ADDR_W-1:0]   core_wr_addr;
    logic                sweep_start;
    logic                sweep_active;
    logic [ADDR_W-1:0]   sweep_addr;
    logic                mem_wr_en;
    logic [ADDR_W-1:0]   mem_wr_addr;
    t_entry              mem_wr_data;

    // Vertex count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_vcount <= i_cfg_wr_data;
        end
    end

    gffc_core #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE),
        .ADDR_W       (ADDR_W)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_block       (sweep_active),
        .i_vcount      (r_vcount),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req         (i_req),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_res         (o_res),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_wr          (core_wr),
        .o_wr_addr     (core_wr_addr),
        .o_sweep_start (sweep_start)
    );

    gffc_sweep #(
        .DEPTH  (MAX_VERTICES),
        .ADDR_W (ADDR_W)
    ) u_sweep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (sweep_start),
        .o_active (sweep_active),
        .o_addr   (sweep_addr)
    );

    // Store write select: clearing pass or vertex commit
    always_comb begin
        if (sweep_active) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_addr;
            mem_wr_data = '0;
        end else begin
            mem_wr_en   = core_wr.en;
            mem_wr_addr = core_wr_addr;
            mem_wr_data = core_wr.entry;
        end
    end

    gffc_color_mem #(
        .DEPTH  (MAX_VERTICES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

### hw/rtl/gffc_color_mem.sv
// Color store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module gffc_color_mem
    import gffc_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_entry            i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_entry            o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/gffc_sweep.sv
// Clearing sequencer that walks the color store once after reset or epoch wrap.
`timescale 1ns / 1ps

module gffc_sweep
    import gffc_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_active,
    output logic [ADDR_W-1:0] o_addr
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic              r_active;
    logic [ADDR_W-1:0] r_addr;

    // One entry per cycle until the last address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b1;
            r_addr   <= '0;
        end else if (r_active) begin
            if (r_addr == LAST_ADDR) begin
                r_active <= 1'b0;
                r_addr   <= '0;
            end else begin
                r_addr <= r_addr + ADDR_W'(1);
            end
        end else if (i_start) begin
            r_active <= 1'b1;
            r_addr   <= '0;
        end
    end

    assign o_active = r_active;
    assign o_addr   = r_addr;

endmodule

### hw/rtl/gffc_core.sv
// Request stage, coloring state, first-fit selection and result register.
`timescale 1ns / 1ps

module gffc_core
    import gffc_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_DEGREE   = 63,
    parameter int ADDR_W       = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_block,
    input  logic [VCOUNT_W-1:0] i_vcount,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_in_req             i_req,
    output logic                o_valid,
    input  logic                i_ready,
    output t_out_req            o_res,
    output logic                o_rd_en,
    output logic [ADDR_W-1:0]   o_rd_addr,
    input  t_entry              i_rd_data,
    output t_wr_ctl             o_wr,
    output logic [ADDR_W-1:0]   o_wr_addr,
    output logic                o_sweep_start
);

    localparam int CNT_W = $clog2(MAX_DEGREE + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DEGREE);

    // Stage and state registers
    logic                  r_s_valid;
    t_in_req               r_s_req;
    logic                  r_fwd;
    logic [COLOR_W-1:0]    r_fwd_color;
    logic [EPOCH_W-1:0]    r_epoch;
    logic [NUM_COLORS-1:0] r_mask;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_fault;
    logic [COLOR_W-1:0]    r_max;
    logic                  r_o_valid;
    t_out_req              r_o_res;

    logic                  n_s_valid;
    logic [NUM_COLORS-1:0] n_mask;
    logic [CNT_W-1:0]      n_cnt;
    logic                  n_fault;
    logic [COLOR_W-1:0]    n_max;

    t_action               s_act;
    logic                  s_is_fin;
    logic                  s_is_start;
    logic                  out_free;
    logic                  s_adv;
    logic                  wrap;
    logic                  accept;
    logic [COLOR_W-1:0]    stored_color;
    logic                  nbr_ok;
    logic                  vtx_ok;
    logic [NUM_COLORS-1:0] free_bit;
    logic [COLORIDX_W-1:0] free_idx;
    logic                  mask_full;
    logic [COLOR_W-1:0]    pick_color;
    logic                  fin_ok;
    t_out_req              fin_res;

    // Handshake and stage control
    always_comb begin
        s_act      = t_action'(r_s_req.action);
        s_is_fin   = r_s_valid && (s_act == ACT_FINISH);
        s_is_start = r_s_valid && (s_act == ACT_START);
        out_free   = !r_o_valid || i_ready;
        s_adv      = r_s_valid && (!s_is_fin || out_free);
        wrap       = s_is_start && (r_epoch == {EPOCH_W{1'b1}});
        o_ready    = !i_block && !wrap && (!r_s_valid || s_adv);
        accept     = i_valid && o_ready;
        n_s_valid  = accept || (r_s_valid && !s_adv);
    end

    // Store read for the incoming request
    always_comb begin
        o_rd_en   = accept;
        o_rd_addr = (t_action'(i_req.action) == ACT_NEIGHBOR) ?
                    ADDR_W'(i_req.neighbor) : ADDR_W'(i_req.vertex);
    end

    // Stored color seen by the stage, with forwarding of the last write
    always_comb begin
        if (r_fwd) begin
            stored_color = r_fwd_color;
        end else if (i_rd_data.epoch == r_epoch) begin
            stored_color = i_rd_data.color;
        end else begin
            stored_color = '0;
        end
    end

    // Range, degree and already-colored checks
    always_comb begin
        nbr_ok = ({1'b0, r_s_req.neighbor} < i_vcount)
              && (32'(r_s_req.neighbor) < 32'(MAX_VERTICES))
              && (r_cnt != CNT_MAX);
        vtx_ok = ({1'b0, r_s_req.vertex} < i_vcount)
              && (32'(r_s_req.vertex) < 32'(MAX_VERTICES))
              && (stored_color == '0);
    end

    // First free color: lowest clear bit of the used mask
    always_comb begin
        free_bit  = ~r_mask & (r_mask + NUM_COLORS'(1));
        mask_full = &r_mask;
        free_idx  = '0;
        for (int i = 0; i < NUM_COLORS; i++) begin
            if (free_bit[i]) begin
                free_idx = free_idx | COLORIDX_W'(i);
            end
        end
        pick_color = {1'b0, free_idx} + COLOR_W'(1);
    end

    // Finish result
    always_comb begin
        fin_ok             = 1'b0;
        fin_res.vertex_out = r_s_req.vertex;
        fin_res.color      = '0;
        fin_res.error      = ERR_OK;
        if (!vtx_ok) begin
            fin_res.error = ERR_VERTEX;
        end else if (r_fault || mask_full) begin
            fin_res.error = ERR_NEIGHBOR;
        end else begin
            fin_ok        = 1'b1;
            fin_res.color = pick_color;
        end
        fin_res.highest_color = (fin_ok && (pick_color > r_max)) ? pick_color : r_max;
    end

    // Next coloring state on commit
    always_comb begin
        n_mask  = r_mask;
        n_cnt   = r_cnt;
        n_fault = r_fault;
        n_max   = r_max;
        if (s_adv) begin
            case (s_act)
                ACT_START: begin
                    n_mask  = '0;
                    n_cnt   = '0;
                    n_fault = 1'b0;
                    n_max   = '0;
                end
                ACT_NEIGHBOR: begin
                    if (!nbr_ok) begin
                        n_fault = 1'b1;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                        if ((stored_color != '0) && (stored_color <= COLOR_W'(NUM_COLORS))) begin
                            n_mask = r_mask
                                   | (NUM_COLORS'(1) << (stored_color - COLOR_W'(1)));
                        end
                    end
                end
                ACT_FINISH: begin
                    n_mask  = '0;
                    n_cnt   = '0;
                    n_fault = 1'b0;
                    n_max   = fin_res.highest_color;
                end
                default: begin
                end
            endcase
        end
    end

    // Store write for an accepted vertex, and clearing pass start on a wrap
    always_comb begin
        o_wr.en          = s_adv && s_is_fin && fin_ok;
        o_wr.entry.epoch = r_epoch;
        o_wr.entry.color = pick_color;
        o_wr_addr        = ADDR_W'(r_s_req.vertex);
        o_sweep_start    = s_adv && wrap;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_epoch   <= '0;
            r_mask    <= '0;
            r_cnt     <= '0;
            r_fault   <= 1'b0;
            r_max     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_s_valid <= n_s_valid;
            r_mask    <= n_mask;
            r_cnt     <= n_cnt;
            r_fault   <= n_fault;
            r_max     <= n_max;
            if (s_adv && s_is_start) begin
                r_epoch <= r_epoch + EPOCH_W'(1);
            end
            if (s_adv && s_is_fin) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s_req     <= i_req;
            r_fwd       <= o_wr.en && (o_wr_addr == o_rd_addr);
            r_fwd_color <= o_wr.entry.color;
        end
        if (s_adv && s_is_fin) begin
            r_o_res <= fin_res;
        end
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_o_res;

endmodule
